// ----- rtl/lowmc_block_cipher_256_macros.svh -----
// ----------------------------------------------------------------------------
// LowMC cipher assertion macros
// Concurrent check wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef LOWMC_BLOCK_CIPHER_256_MACROS_SVH
`define LOWMC_BLOCK_CIPHER_256_MACROS_SVH
`ifndef SYNTHESIS
`define LMC_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define LMC_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define LMC_ASSERT_IMP(lbl, a, c)
`define LMC_ASSERT_NXT(lbl, a, c)
`endif
`endif

// ----- rtl/lmc_pkg.sv -----
// ----------------------------------------------------------------------------
// LowMC cipher package
// Sizes, command codes, sequencer states and the S-box layer.
// ----------------------------------------------------------------------------
package lmc_pkg;

	localparam int ROUNDS     = 16;
	localparam int BLOCK_BITS = 256;
	localparam int MAX_BOXES  = 21;
	localparam int RND_W      = $clog2(ROUNDS + 1);
	localparam int RC_AW      = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam int LIN_DEPTH  = ROUNDS * BLOCK_BITS;
	localparam int KEY_DEPTH  = (ROUNDS + 1) * BLOCK_BITS;
	localparam int LIN_AW     = $clog2(LIN_DEPTH);
	localparam int KEY_AW     = $clog2(KEY_DEPTH);
	localparam int CNT_W      = 9;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_BITS + 1);

	localparam logic [2:0] FWD_BOX [8] = '{3'd0, 3'd1, 3'd3, 3'd6, 3'd7, 3'd4, 3'd5, 3'd2};
	localparam logic [2:0] REV_BOX [8] = '{3'd0, 3'd1, 3'd7, 3'd2, 3'd5, 3'd6, 3'd3, 3'd4};

	typedef enum logic [2:0] {
		CMD_LIN  = 3'd0,
		CMD_INV  = 3'd1,
		CMD_KEY  = 3'd2,
		CMD_RC   = 3'd3,
		CMD_SETK = 3'd4,
		CMD_ENC  = 3'd5,
		CMD_DEC  = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_KEY,
		S_ENC,
		S_DEC_ADD,
		S_DEC,
		S_DEC_FIN,
		S_DONE
	} state_t;

	// Substitution on the low n boxes of word 0; a count above MAX_BOXES leaves the word unchanged.
	function automatic logic [63:0] sbox_word(input logic [63:0] w, input logic [6:0] n,
		input logic inv);
		logic [63:0] r;
		logic [2:0]  b;
		r = w;
		if (int'(n) <= MAX_BOXES) begin
			for (int j = 0; j < MAX_BOXES; j++) begin
				if (j < int'(n)) begin
					b = w[3*j +: 3];
					r[3*j +: 3] = inv ? REV_BOX[b] : FWD_BOX[b];
				end
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/lmc_ram.sv -----
// ----------------------------------------------------------------------------
// LowMC generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lmc_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/lmc_parity.sv -----
// ----------------------------------------------------------------------------
// LowMC row parity unit
// Computes one output bit of a matrix-vector product per cycle while en is high.
// ----------------------------------------------------------------------------
module lmc_parity (
	input  logic                          clk,
	input  logic                          en,
	input  logic [7:0]                    idx,
	input  logic [lmc_pkg::BLOCK_BITS-1:0] row,
	input  logic [lmc_pkg::BLOCK_BITS-1:0] vec,
	output logic [lmc_pkg::BLOCK_BITS-1:0] acc
);
	import lmc_pkg::*;

	logic [BLOCK_BITS-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q[idx] <= ^(row & vec);
		end
	end

	assign acc = acc_q;

endmodule

// ----- rtl/lowmc_block_cipher_256.sv -----
// ----------------------------------------------------------------------------
// LowMC block cipher, 256-bit state
// Loadable matrices and constants, key schedule, encrypt and decrypt.
// ----------------------------------------------------------------------------
// Usage: a transaction on the request channel (req_valid/req_ready) carries a
// command. Row and constant loads and unused commands complete on acceptance
// and leave the block idle. Set key computes all 17 round keys, one matrix
// row parity per cycle; encrypt runs 16 rounds, and decrypt 16 rounds with a
// key and constant addition step before each. The single shared parity unit
// is fed by one row read per cycle from the matrix RAMs. Encrypt and decrypt
// each return one transaction on the result channel (rsp_valid/rsp_ready),
// whose output register holds the block until taken; set key returns none.
// The block is not ready while a command runs. If the receiver stalls, a
// finished result waits inside the block until the output register is free.
// The S-box count register must be written by cfg_we/cfg_data only while
// idle; the block itself does not enforce this.
// Reset clears control state, the master key, and sets the S-box count to 10;
// matrix rows, round constants and round keys are undefined until written.
// ----------------------------------------------------------------------------
`include "lowmc_block_cipher_256_macros.svh"

module lowmc_block_cipher_256 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  command,
	input  logic [4:0]  round_index,
	input  logic [7:0]  row_index,
	input  logic [63:0] data_word0,
	input  logic [63:0] data_word1,
	input  logic [63:0] data_word2,
	input  logic [63:0] data_word3,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        result_kind,
	output logic [63:0] out_word0,
	output logic [63:0] out_word1,
	output logic [63:0] out_word2,
	output logic [63:0] out_word3
);
	import lmc_pkg::*;

	state_t state_q, state_d;

	logic [6:0]            nbox_q;
	logic [BLOCK_BITS-1:0] mkey_q;
	logic [BLOCK_BITS-1:0] data_q;
	logic                  kind_q;
	logic [RND_W-1:0]      r_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  rsp_valid_q;
	logic                  rsp_kind_q;
	logic [BLOCK_BITS-1:0] rsp_q;

	logic [BLOCK_BITS-1:0] rk_q [ROUNDS+1];
	logic [BLOCK_BITS-1:0] rc_q [ROUNDS];

	logic                  accept;
	cmd_t                  cmd;
	logic                  rnd_ok;
	logic                  key_rnd_ok;
	logic [BLOCK_BITS-1:0] din;
	logic [RND_W-1:0]      mat_round;
	logic                  in_mat;
	logic                  mat_end;
	logic [BLOCK_BITS-1:0] lin_rd, inv_rd, key_rd, row_sel, vec_sel, acc;
	logic [BLOCK_BITS-1:0] rk_cur, rc_cur, enc_x, dec_y;
	logic [RND_W-1:0]      r_m1;
	logic                  out_free;

	assign din     = {data_word3, data_word2, data_word1, data_word0};
	assign cmd     = cmd_t'(command);
	assign accept  = req_valid && req_ready;
	assign rnd_ok  = int'(round_index) < ROUNDS;
	assign key_rnd_ok = int'(round_index) <= ROUNDS;
	assign out_free = !rsp_valid_q || rsp_ready;

	// Round keys are read at round r, round constants at round r-1.
	assign r_m1   = r_q - RND_W'(1);
	assign rk_cur = rk_q[r_q];
	assign rc_cur = rc_q[r_m1[RC_AW-1:0]];

	assign in_mat    = (state_q == S_KEY) || (state_q == S_ENC) || (state_q == S_DEC);
	assign mat_end   = in_mat && (cnt_q == CNT_LAST);
	assign mat_round = (state_q == S_KEY) ? r_q : r_m1;

	// Matrix RAMs; the row for output bit cnt is read while cnt is below 256
	// and reaches the parity unit in the next cycle.
	lmc_ram #(.DEPTH(LIN_DEPTH), .WIDTH(BLOCK_BITS)) u_lin (
		.clk   (clk),
		.we    (accept && (cmd == CMD_LIN) && rnd_ok),
		.waddr (LIN_AW'({round_index, row_index})),
		.wdata (din),
		.raddr (LIN_AW'({mat_round, cnt_q[7:0]})),
		.rdata (lin_rd)
	);

	lmc_ram #(.DEPTH(LIN_DEPTH), .WIDTH(BLOCK_BITS)) u_inv (
		.clk   (clk),
		.we    (accept && (cmd == CMD_INV) && rnd_ok),
		.waddr (LIN_AW'({round_index, row_index})),
		.wdata (din),
		.raddr (LIN_AW'({mat_round, cnt_q[7:0]})),
		.rdata (inv_rd)
	);

	lmc_ram #(.DEPTH(KEY_DEPTH), .WIDTH(BLOCK_BITS)) u_key (
		.clk   (clk),
		.we    (accept && (cmd == CMD_KEY) && key_rnd_ok),
		.waddr (KEY_AW'({round_index, row_index})),
		.wdata (din),
		.raddr (KEY_AW'({mat_round, cnt_q[7:0]})),
		.rdata (key_rd)
	);

	always_comb begin
		case (state_q)
			S_KEY:   row_sel = key_rd;
			S_ENC:   row_sel = lin_rd;
			default: row_sel = inv_rd;
		endcase
	end

	assign vec_sel = (state_q == S_KEY) ? mkey_q : data_q;

	lmc_parity u_par (
		.clk (clk),
		.en  (in_mat && (cnt_q != '0) && !mat_end),
		.idx (8'(cnt_q - CNT_W'(1))),
		.row (row_sel),
		.vec (vec_sel),
		.acc (acc)
	);

	// End of an encrypt round: constant and key added, then the next S-box
	// layer is folded in unless this was the last round.
	assign enc_x = acc ^ rc_cur ^ rk_cur;
	assign dec_y = {acc[BLOCK_BITS-1:64], sbox_word(acc[63:0], nbox_q, 1'b1)};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_SETK: state_d = S_KEY;
						CMD_ENC:  state_d = S_ENC;
						CMD_DEC:  state_d = S_DEC_ADD;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_KEY: begin
				if (mat_end && (int'(r_q) == ROUNDS)) begin
					state_d = S_IDLE;
				end
			end
			S_ENC: begin
				if (mat_end && (int'(r_q) == ROUNDS)) begin
					state_d = S_DONE;
				end
			end
			S_DEC_ADD: state_d = S_DEC;
			S_DEC: begin
				if (mat_end) begin
					state_d = (r_q == RND_W'(1)) ? S_DEC_FIN : S_DEC_ADD;
				end
			end
			S_DEC_FIN: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign req_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbox_q      <= 7'd10;
			mkey_q      <= '0;
			r_q         <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				nbox_q <= cfg_data;
			end
			// A finished block refills the output register as it empties.
			if ((state_q == S_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (in_mat) begin
				cnt_q <= mat_end ? '0 : cnt_q + CNT_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (cmd == CMD_SETK)) begin
						mkey_q <= din;
					end
					if (accept && (cmd == CMD_ENC)) begin
						r_q <= RND_W'(1);
					end
					if (accept && (cmd == CMD_DEC)) begin
						r_q <= RND_W'(ROUNDS);
					end
				end
				S_KEY: begin
					if (mat_end) begin
						r_q <= (int'(r_q) == ROUNDS) ? '0 : r_q + RND_W'(1);
					end
				end
				S_ENC: begin
					if (mat_end) begin
						r_q <= (int'(r_q) == ROUNDS) ? '0 : r_q + RND_W'(1);
					end
				end
				S_DEC: begin
					if (mat_end) begin
						r_q <= r_m1;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers: working block, key and constant stores, result.
	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_RC) && rnd_ok) begin
			rc_q[round_index[RC_AW-1:0]] <= din;
		end
		case (state_q)
			S_IDLE: begin
				if (accept && (cmd == CMD_ENC)) begin
					data_q <= {din[BLOCK_BITS-1:64] ^ rk_cur[BLOCK_BITS-1:64],
						sbox_word(din[63:0] ^ rk_cur[63:0], nbox_q, 1'b0)};
					kind_q <= 1'b0;
				end
				if (accept && (cmd == CMD_DEC)) begin
					data_q <= din;
					kind_q <= 1'b1;
				end
			end
			S_KEY: begin
				if (mat_end) begin
					rk_q[r_q] <= acc;
				end
			end
			S_ENC: begin
				if (mat_end) begin
					if (int'(r_q) == ROUNDS) begin
						data_q <= enc_x;
					end else begin
						data_q <= {enc_x[BLOCK_BITS-1:64],
							sbox_word(enc_x[63:0], nbox_q, 1'b0)};
					end
				end
			end
			S_DEC_ADD: data_q <= data_q ^ rk_cur ^ rc_cur;
			S_DEC: begin
				if (mat_end) begin
					data_q <= dec_y;
				end
			end
			S_DEC_FIN: data_q <= data_q ^ rk_cur;
			S_DONE: begin
				if (out_free) begin
					rsp_q      <= data_q;
					rsp_kind_q <= kind_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid   = rsp_valid_q;
	assign result_kind = rsp_kind_q;
	assign out_word0   = rsp_q[63:0];
	assign out_word1   = rsp_q[127:64];
	assign out_word2   = rsp_q[191:128];
	assign out_word3   = rsp_q[255:192];

	// The round counter rests at zero whenever a new command may enter.
	`LMC_ASSERT_IMP(a_idle_round, req_ready, r_q == '0)
	// The row counter never runs past the drain cycle of the last row.
	`LMC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CNT_LAST)
	// A finished block moves into a free output register on the next edge.
	`LMC_ASSERT_NXT(a_done_out, (state_q == S_DONE) && out_free, rsp_valid && req_ready)

endmodule
